### design/torq_pkg.sv
// Shared types and constants of the timestamp-ordered request queue.
// Used by the channel interfaces, torq_set and the top level; depends on nothing.
package torq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SET_DEPTH   = 16;
    localparam int DEF_ID_WIDTH    = 16;
    localparam int DEF_STAMP_WIDTH = 32;

    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 4;
    localparam int FILL_W    = 5;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_LIMIT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE  = 3'd0,
        CMD_DEQUEUE  = 3'd1,
        CMD_READ_POS = 3'd2,
        CMD_ENTER    = 3'd3,
        CMD_LEAVE    = 3'd4,
        CMD_QUERY    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_ENQ,
        Q_DEQ,
        Q_RDPOS,
        Q_MEMB,
        Q_DONE
    } q_state_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } s_state_t;

    typedef struct packed {
        logic go;
        cmd_t cmd;
    } set_req_t;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic              in_set;
        logic              full;
        logic [FILL_W-1:0] fill;
    } set_rsp_t;

endpackage

### design/torq_if.sv
// Valid/ready channel interfaces for the command and result transfers.
// Depends on torq_pkg for the field widths.
interface torq_req_if #(
    parameter int ID_W = torq_pkg::DEF_ID_WIDTH,
    parameter int ST_W = torq_pkg::DEF_STAMP_WIDTH
);
    import torq_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  req_id;
    logic [ST_W-1:0]  stamp;
    logic [POS_W-1:0] pos;

    modport source (output valid, cmd, req_id, stamp, pos, input ready);
    modport sink   (input valid, cmd, req_id, stamp, pos, output ready);
endinterface

interface torq_rsp_if #(
    parameter int ID_W = torq_pkg::DEF_ID_WIDTH,
    parameter int ST_W = torq_pkg::DEF_STAMP_WIDTH
);
    import torq_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [ID_W-1:0]   entry_id;
    logic [ST_W-1:0]   entry_stamp;
    logic              in_queue;
    logic              in_set;
    logic              at_head;
    logic              queue_full;
    logic              set_full;
    logic [FILL_W-1:0] queue_fill;
    logic [FILL_W-1:0] set_fill;

    modport source (output valid, ok, entry_id, entry_stamp, in_queue, in_set, at_head,
                     queue_full, set_full, queue_fill, set_fill, input ready);
    modport sink   (input valid, ok, entry_id, entry_stamp, in_queue, in_set, at_head,
                    queue_full, set_full, queue_fill, set_fill, output ready);
endinterface

### design/torq_cmp.sv
// Shared compare unit: orders a key against one queue entry and matches ids.
// Stand-alone; no package needed.
module torq_cmp #(
    parameter int ID_W = 16,
    parameter int ST_W = 32
) (
    input  logic [ID_W-1:0] key_id,
    input  logic [ST_W-1:0] key_stamp,
    input  logic [ID_W-1:0] ent_id,
    input  logic [ST_W-1:0] ent_stamp,
    output logic            key_lt,
    output logic            id_eq
);
    // The key sorts before the entry on a lower stamp, or on an equal stamp and lower id.
    assign key_lt = (key_stamp < ent_stamp) || ((key_stamp == ent_stamp) && (key_id < ent_id));
    assign id_eq  = (key_id == ent_id);
endmodule

### design/torq_qmem.sv
// Queue entry memory: ids and stamps, one write and one registered read per cycle.
// Stand-alone; no package needed.
module torq_qmem #(
    parameter int DEPTH = 16,
    parameter int ID_W  = 16,
    parameter int ST_W  = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ID_W-1:0]          wr_id,
    input  logic [ST_W-1:0]          wr_stamp,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ID_W-1:0]          rd_id,
    output logic [ST_W-1:0]          rd_stamp
);
    logic [ID_W-1:0] id_mem    [DEPTH];
    logic [ST_W-1:0] stamp_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]    <= wr_id;
            stamp_mem[wr_addr] <= wr_stamp;
        end
        if (rd_en)
        begin
            rd_id    <= id_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end
endmodule

### design/torq_set.sv
// Inside set: id memory with per-entry valid bits, scanned one entry per cycle.
// Depends on torq_pkg for the command codes and the request/response structs.
module torq_set #(
    parameter int SET_DEPTH = torq_pkg::DEF_SET_DEPTH,
    parameter int ID_W      = torq_pkg::DEF_ID_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  torq_pkg::set_req_t          req,
    input  logic [ID_W-1:0]             id,
    input  logic [torq_pkg::CFG_W-1:0]  lim,
    output torq_pkg::set_rsp_t          rsp
);
    import torq_pkg::*;

    localparam int SA  = $clog2(SET_DEPTH);
    localparam int SC  = $clog2(SET_DEPTH + 1);
    localparam int SLW = (SC > CFG_W) ? SC : CFG_W;

    s_state_t state_reg, state_next;
    cmd_t     cmd_reg;

    logic [SC-1:0]        idx_reg, idx_next;
    logic [SA-1:0]        raddr_reg, raddr_next;
    logic                 rvalid_reg, rvalid_next;
    logic                 found_reg, found_next;
    logic [SA-1:0]        fidx_reg, fidx_next;
    logic                 free_reg, free_next;
    logic [SA-1:0]        free_idx_reg, free_idx_next;
    logic [SC-1:0]        cnt_reg, cnt_next;
    logic [SET_DEPTH-1:0] valid_reg;
    set_rsp_t             rsp_reg, rsp_next;

    logic [ID_W-1:0] id_mem [SET_DEPTH];
    logic [ID_W-1:0] rd_id_reg;

    logic          rd_en, wr_en, clr_en, scan_last;
    logic [SA-1:0] rd_addr;
    logic [SLW-1:0] lim_ext, seff;
    logic          room;

    // A limit of zero acts as one, and one above the depth acts as the depth.
    assign lim_ext = SLW'(lim);
    always_comb
    begin
        if (lim == '0)
            seff = SLW'(1);
        else if (lim_ext > SLW'(SET_DEPTH))
            seff = SLW'(SET_DEPTH);
        else
            seff = lim_ext;
    end

    assign room = SLW'(cnt_reg) < seff;
    assign rsp  = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        raddr_next    = raddr_reg;
        rvalid_next   = rvalid_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cnt_next      = cnt_reg;
        rsp_next      = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        clr_en        = 1'b0;
        scan_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    idx_next    = '0;
                    rvalid_next = 1'b0;
                    found_next  = 1'b0;
                    free_next   = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (rvalid_reg)
                begin
                    if (valid_reg[raddr_reg] && (rd_id_reg == id) && !found_reg)
                    begin
                        found_next = 1'b1;
                        fidx_next  = raddr_reg;
                    end
                    if (!valid_reg[raddr_reg] && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = raddr_reg;
                    end
                end

                if (idx_reg != SC'(SET_DEPTH))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = idx_reg[SA-1:0];
                    raddr_next  = idx_reg[SA-1:0];
                    idx_next    = idx_reg + SC'(1);
                    rvalid_next = 1'b1;
                end
                else
                begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg)
                    begin
                        scan_last     = 1'b1;
                        rsp_next.done = 1'b1;
                        unique case (cmd_reg)
                            CMD_ENTER:
                            begin
                                if (found_reg)
                                begin
                                    rsp_next.ok     = 1'b1;
                                    rsp_next.in_set = 1'b1;
                                end
                                else if (room)
                                begin
                                    // A free entry exists whenever the count is below the limit.
                                    wr_en           = 1'b1;
                                    cnt_next        = cnt_reg + SC'(1);
                                    rsp_next.ok     = 1'b1;
                                    rsp_next.in_set = 1'b1;
                                end
                            end
                            CMD_LEAVE:
                            begin
                                if (found_reg)
                                begin
                                    clr_en      = 1'b1;
                                    cnt_next    = cnt_reg - SC'(1);
                                    rsp_next.ok = 1'b1;
                                end
                            end
                            default:
                                rsp_next.in_set = found_reg;
                        endcase
                        rsp_next.full = SLW'(cnt_next) >= seff;
                        rsp_next.fill = FILL_W'(cnt_next);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
            cnt_reg    <= cnt_next;
            rsp_reg    <= rsp_next;
            if (wr_en)
                valid_reg[free_idx_reg] <= 1'b1;
            if (clr_en)
                valid_reg[fidx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go && (state_reg == S_IDLE))
            cmd_reg <= req.cmd;
        idx_reg      <= idx_next;
        raddr_reg    <= raddr_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            id_mem[free_idx_reg] <= id;
        if (rd_en)
            rd_id_reg <= id_mem[rd_addr];
    end
endmodule

### design/timestamp_ordered_request_queue.sv
// Timestamp-ordered request queue with an inside set: top level and queue sequencer.
// Depends on torq_pkg, torq_if, torq_cmp, torq_qmem and torq_set.
//
// Commands arrive on the req channel and each gives exactly one transfer on the
// rsp channel; both are valid/ready. The limits are written through cfg_we,
// cfg_idx and cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce. One command is worked on at a time:
// req.ready is high only between commands. The queue memory has one read port,
// read one entry per cycle. An enqueue walks from the tail to place the key,
// then a membership pass scans from the head; a dequeue makes two passes: one
// moves entries, one finds the id for the membership flags. A rejected enqueue
// or a query makes only the membership pass, and a position read reads its
// entry before that pass. The inside set is scanned in parallel, and the
// result waits for both. req.ready returns with the result, so a command holds
// the block until its result is loaded into the output register.
// Reset empties the queue and the set at once (no clearing pass) and sets both
// limits to 16. A result waits in the output register until rsp.ready; the next
// command is still taken and worked on, and its result then waits for the
// register to free.
module timestamp_ordered_request_queue #(
    parameter int QUEUE_DEPTH = torq_pkg::DEF_QUEUE_DEPTH,
    parameter int SET_DEPTH   = torq_pkg::DEF_SET_DEPTH,
    parameter int ID_WIDTH    = torq_pkg::DEF_ID_WIDTH,
    parameter int STAMP_WIDTH = torq_pkg::DEF_STAMP_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [torq_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [torq_pkg::CFG_W-1:0]     cfg_data,
    torq_req_if.sink                       req,
    torq_rsp_if.source                     rsp
);
    import torq_pkg::*;

    localparam int QA  = $clog2(QUEUE_DEPTH);
    localparam int QC  = $clog2(QUEUE_DEPTH + 1);
    localparam int QLW = (QC > CFG_W) ? QC : CFG_W;
    localparam int PCW = (QC > POS_W) ? QC : POS_W;

    q_state_t state_reg, state_next;

    cmd_t                   cmd_reg;
    logic [ID_WIDTH-1:0]    id_reg;
    logic [STAMP_WIDTH-1:0] stamp_reg;
    logic [POS_W-1:0]       pos_reg;

    logic [QC-1:0] count_reg, count_next;
    logic [QC-1:0] idx_reg, idx_next;
    logic [QC-1:0] idx_m1;
    logic [QA-1:0] raddr_reg, raddr_next;
    logic          rvalid_reg, rvalid_next;
    logic          found_reg, found_next;
    logic          hit_reg, hit_next;
    logic          head_reg, head_next;
    logic          okq_reg, okq_next;

    logic [ID_WIDTH-1:0]    entry_id_reg, entry_id_next;
    logic [STAMP_WIDTH-1:0] entry_stamp_reg, entry_stamp_next;

    logic [CFG_W-1:0] qlim_reg, slim_reg;
    logic [QLW-1:0]   qlim_ext, qeff;
    logic             q_full, pos_ok;

    set_req_t set_req;
    set_rsp_t set_rsp, set_res_reg;
    logic     set_got_reg, set_got_next;

    logic                   qm_wr_en, qm_rd_en;
    logic [QA-1:0]          qm_wr_addr, qm_rd_addr;
    logic [ID_WIDTH-1:0]    qm_wr_id, qm_rd_id;
    logic [STAMP_WIDTH-1:0] qm_wr_stamp, qm_rd_stamp;
    logic                   key_lt, id_eq;

    logic accept, step_last, out_load, ok_final;

    logic                   out_valid_reg;
    logic                   out_ok_reg;
    logic [ID_WIDTH-1:0]    out_entry_id_reg;
    logic [STAMP_WIDTH-1:0] out_entry_stamp_reg;
    logic                   out_in_queue_reg, out_in_set_reg, out_at_head_reg;
    logic                   out_queue_full_reg, out_set_full_reg;
    logic [FILL_W-1:0]      out_queue_fill_reg, out_set_fill_reg;

    assign req.ready = (state_reg == Q_IDLE);
    assign accept    = req.valid && req.ready;

    // A limit of zero acts as one, and one above the depth acts as the depth.
    assign qlim_ext = QLW'(qlim_reg);
    always_comb
    begin
        if (qlim_reg == '0)
            qeff = QLW'(1);
        else if (qlim_ext > QLW'(QUEUE_DEPTH))
            qeff = QLW'(QUEUE_DEPTH);
        else
            qeff = qlim_ext;
    end

    assign q_full = QLW'(count_reg) >= qeff;
    assign pos_ok = PCW'(pos_reg) < PCW'(count_reg);
    assign idx_m1 = idx_reg - QC'(1);

    assign set_req.go  = accept;
    assign set_req.cmd = cmd_t'(req.cmd);

    torq_cmp #(
        .ID_W (ID_WIDTH),
        .ST_W (STAMP_WIDTH)
    ) u_cmp (
        .key_id    (id_reg),
        .key_stamp (stamp_reg),
        .ent_id    (qm_rd_id),
        .ent_stamp (qm_rd_stamp),
        .key_lt    (key_lt),
        .id_eq     (id_eq)
    );

    torq_qmem #(
        .DEPTH (QUEUE_DEPTH),
        .ID_W  (ID_WIDTH),
        .ST_W  (STAMP_WIDTH)
    ) u_qmem (
        .clk      (clk),
        .wr_en    (qm_wr_en),
        .wr_addr  (qm_wr_addr),
        .wr_id    (qm_wr_id),
        .wr_stamp (qm_wr_stamp),
        .rd_en    (qm_rd_en),
        .rd_addr  (qm_rd_addr),
        .rd_id    (qm_rd_id),
        .rd_stamp (qm_rd_stamp)
    );

    torq_set #(
        .SET_DEPTH (SET_DEPTH),
        .ID_W      (ID_WIDTH)
    ) u_set (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (set_req),
        .id    (id_reg),
        .lim   (slim_reg),
        .rsp   (set_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            Q_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_ENQUEUE:  state_next = q_full ? Q_MEMB : Q_ENQ;
                        CMD_DEQUEUE:  state_next = Q_DEQ;
                        CMD_READ_POS: state_next = Q_RDPOS;
                        default:      state_next = Q_MEMB;
                    endcase
                end
            end
            Q_ENQ, Q_DEQ, Q_RDPOS:
            begin
                if (step_last)
                    state_next = Q_MEMB;
            end
            Q_MEMB:
            begin
                if (step_last)
                    state_next = Q_DONE;
            end
            Q_DONE:
            begin
                if (out_load)
                    state_next = Q_IDLE;
            end
            default:
                state_next = Q_IDLE;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        idx_next         = idx_reg;
        raddr_next       = raddr_reg;
        rvalid_next      = rvalid_reg;
        found_next       = found_reg;
        hit_next         = hit_reg;
        head_next        = head_reg;
        okq_next         = okq_reg;
        entry_id_next    = entry_id_reg;
        entry_stamp_next = entry_stamp_reg;
        set_got_next     = set_got_reg || set_rsp.done;
        qm_wr_en         = 1'b0;
        qm_wr_addr       = '0;
        qm_wr_id         = id_reg;
        qm_wr_stamp      = stamp_reg;
        qm_rd_en         = 1'b0;
        qm_rd_addr       = '0;
        step_last        = 1'b0;
        out_load         = 1'b0;

        unique case (state_reg)
            Q_IDLE:
            begin
                if (accept)
                begin
                    // A rejected enqueue goes straight to the membership pass,
                    // which scans from the head.
                    idx_next         = ((cmd_t'(req.cmd) == CMD_ENQUEUE) && !q_full) ?
                                       count_reg : '0;
                    rvalid_next      = 1'b0;
                    found_next       = 1'b0;
                    hit_next         = 1'b0;
                    head_next        = 1'b0;
                    okq_next         = 1'b0;
                    entry_id_next    = '0;
                    entry_stamp_next = '0;
                    set_got_next     = 1'b0;
                end
            end
            Q_ENQ:
            begin
                // Walk from the tail: every entry that sorts after the key moves up one
                // place, and the key lands just above the first one that does not.
                if (rvalid_reg)
                begin
                    qm_wr_en   = 1'b1;
                    qm_wr_addr = raddr_reg + QA'(1);
                    if (key_lt)
                    begin
                        qm_wr_id    = qm_rd_id;
                        qm_wr_stamp = qm_rd_stamp;
                    end
                    else
                        step_last = 1'b1;
                end
                else if (idx_reg == '0)
                begin
                    qm_wr_en   = 1'b1;
                    qm_wr_addr = '0;
                    step_last  = 1'b1;
                end

                if (step_last)
                begin
                    count_next  = count_reg + QC'(1);
                    okq_next    = 1'b1;
                    idx_next    = '0;
                    rvalid_next = 1'b0;
                end
                else if (idx_reg != '0)
                begin
                    qm_rd_en    = 1'b1;
                    qm_rd_addr  = idx_m1[QA-1:0];
                    raddr_next  = idx_m1[QA-1:0];
                    idx_next    = idx_m1;
                    rvalid_next = 1'b1;
                end
                else
                    rvalid_next = 1'b0;
            end
            Q_DEQ:
            begin
                // Walk from the head: once the first matching entry is seen, every
                // later entry moves down one place over it.
                if (rvalid_reg)
                begin
                    if (found_reg)
                    begin
                        qm_wr_en    = 1'b1;
                        qm_wr_addr  = raddr_reg - QA'(1);
                        qm_wr_id    = qm_rd_id;
                        qm_wr_stamp = qm_rd_stamp;
                    end
                    else if (id_eq)
                        found_next = 1'b1;
                end

                if (idx_reg != count_reg)
                begin
                    qm_rd_en    = 1'b1;
                    qm_rd_addr  = idx_reg[QA-1:0];
                    raddr_next  = idx_reg[QA-1:0];
                    idx_next    = idx_reg + QC'(1);
                    rvalid_next = 1'b1;
                end
                else
                begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg)
                    begin
                        step_last = 1'b1;
                        okq_next  = found_reg;
                        idx_next  = '0;
                        if (found_reg)
                            count_next = count_reg - QC'(1);
                    end
                end
            end
            Q_RDPOS:
            begin
                if (rvalid_reg)
                begin
                    entry_id_next    = qm_rd_id;
                    entry_stamp_next = qm_rd_stamp;
                    okq_next         = 1'b1;
                    rvalid_next      = 1'b0;
                    step_last        = 1'b1;
                end
                else if (pos_ok)
                begin
                    qm_rd_en    = 1'b1;
                    qm_rd_addr  = QA'(pos_reg);
                    rvalid_next = 1'b1;
                end
                else
                    step_last = 1'b1;
            end
            Q_MEMB:
            begin
                if (rvalid_reg && id_eq)
                begin
                    hit_next = 1'b1;
                    if (raddr_reg == '0)
                        head_next = 1'b1;
                end

                if (idx_reg != count_reg)
                begin
                    qm_rd_en    = 1'b1;
                    qm_rd_addr  = idx_reg[QA-1:0];
                    raddr_next  = idx_reg[QA-1:0];
                    idx_next    = idx_reg + QC'(1);
                    rvalid_next = 1'b1;
                end
                else
                begin
                    rvalid_next = 1'b0;
                    if (!rvalid_reg)
                        step_last = 1'b1;
                end
            end
            Q_DONE:
            begin
                if (set_got_reg && (!out_valid_reg || rsp.ready))
                    out_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ENQUEUE, CMD_DEQUEUE, CMD_READ_POS: ok_final = okq_reg;
            CMD_ENTER, CMD_LEAVE:                   ok_final = set_res_reg.ok;
            CMD_QUERY:                              ok_final = 1'b1;
            default:                                ok_final = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= Q_IDLE;
            count_reg     <= '0;
            rvalid_reg    <= 1'b0;
            set_got_reg   <= 1'b0;
            qlim_reg      <= LIMIT_RESET;
            slim_reg      <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rvalid_reg  <= rvalid_next;
            set_got_reg <= set_got_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_QUEUE_LIMIT:  qlim_reg <= cfg_data;
                    CFG_INSIDE_LIMIT: slim_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(req.cmd);
            id_reg    <= req.req_id;
            stamp_reg <= req.stamp;
            pos_reg   <= req.pos;
        end
        idx_reg         <= idx_next;
        raddr_reg       <= raddr_next;
        found_reg       <= found_next;
        hit_reg         <= hit_next;
        head_reg        <= head_next;
        okq_reg         <= okq_next;
        entry_id_reg    <= entry_id_next;
        entry_stamp_reg <= entry_stamp_next;
        if (set_rsp.done)
            set_res_reg <= set_rsp;
        if (out_load)
        begin
            out_ok_reg          <= ok_final;
            out_entry_id_reg    <= entry_id_reg;
            out_entry_stamp_reg <= entry_stamp_reg;
            out_in_queue_reg    <= hit_reg;
            out_in_set_reg      <= set_res_reg.in_set;
            out_at_head_reg     <= head_reg;
            out_queue_full_reg  <= q_full;
            out_set_full_reg    <= set_res_reg.full;
            out_queue_fill_reg  <= FILL_W'(count_reg);
            out_set_fill_reg    <= set_res_reg.fill;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.entry_id    = out_entry_id_reg;
    assign rsp.entry_stamp = out_entry_stamp_reg;
    assign rsp.in_queue    = out_in_queue_reg;
    assign rsp.in_set      = out_in_set_reg;
    assign rsp.at_head     = out_at_head_reg;
    assign rsp.queue_full  = out_queue_full_reg;
    assign rsp.set_full    = out_set_full_reg;
    assign rsp.queue_fill  = out_queue_fill_reg;
    assign rsp.set_fill    = out_set_fill_reg;
endmodule

### design/torq_chk.sv
// Port-level checks for the request queue, bound to the top level.
// Depends only on the top level's ports.
module torq_chk #(
    parameter int ID_W = 16,
    parameter int ST_W = 32
) (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input logic            rsp_ok,
    input logic [ID_W-1:0] rsp_entry_id,
    input logic [ST_W-1:0] rsp_entry_stamp,
    input logic            rsp_in_queue,
    input logic            rsp_at_head
);
    // Only one command is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command taken while another was in work");

    // The head of the queue is always a member of it.
    a_head_in_queue: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_at_head |-> rsp_in_queue)
        else $error("at_head reported for an id not in the queue");

    // Entry fields carry data only for a successful position read.
    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> (rsp_entry_id == '0) && (rsp_entry_stamp == '0))
        else $error("entry fields non-zero on a failed command");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_entry_stamp))
        else $error("stalled result transfer changed");
endmodule

bind timestamp_ordered_request_queue torq_chk #(
    .ID_W (ID_WIDTH),
    .ST_W (STAMP_WIDTH)
) u_torq_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_entry_id    (rsp.entry_id),
    .rsp_entry_stamp (rsp.entry_stamp),
    .rsp_in_queue    (rsp.in_queue),
    .rsp_at_head     (rsp.at_head)
);

### test/tb_timestamp_ordered_request_queue.sv
// Self-checking testbench for the timestamp-ordered request queue.
// Drives commands through torq_req_if, checks every result transfer on torq_rsp_if
// against an in-bench predictor or a written-in result; depends on torq_pkg, torq_if and the block itself.
`timescale 1ns / 100ps

module tb_timestamp_ordered_request_queue;
    import torq_pkg::*;

    localparam int QDEPTH   = DEF_QUEUE_DEPTH;
    localparam int SDEPTH   = DEF_SET_DEPTH;
    localparam int N_PHASE  = 6;
    localparam int PHASE_ITEMS = 325;
    localparam int WATCHDOG = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        logic              ok;
        logic [15:0]       entry_id;
        logic [31:0]       entry_stamp;
        logic              in_queue;
        logic              in_set;
        logic              at_head;
        logic              queue_full;
        logic              set_full;
        logic [FILL_W-1:0] queue_fill;
        logic [FILL_W-1:0] set_fill;
    } result_t;

    typedef struct {
        bit               is_cfg;
        logic [CMD_W-1:0] c;
        logic [15:0]      id;
        logic [31:0]      st;
        logic [POS_W-1:0] p;
        bit               lit;
        result_t          want;
        logic [CFG_W-1:0] ql;
        logic [CFG_W-1:0] sl;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    torq_req_if req_ch ();
    torq_rsp_if rsp_ch ();

    timestamp_ordered_request_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    always #4 clk = ~clk;

    // Predicted contents of the queue, the inside set and the limit registers.
    logic [15:0]      q_id [QDEPTH];
    logic [31:0]      q_st [QDEPTH];
    int               q_cnt;
    logic [15:0]      s_id [SDEPTH];
    bit               s_vld [SDEPTH];
    logic [CFG_W-1:0] qlim_reg;
    logic [CFG_W-1:0] slim_reg;

    result_t   awaited_res [$];
    plan_row_t plan [$];
    int        errors;
    int        snd_idle;
    int        rcv_idle;
    int        idle_cycles;

    int ph_qlim [N_PHASE] = '{16, 4, 0, 31, 1, 9};
    int ph_slim [N_PHASE] = '{16, 3, 1, 31, 0, 16};
    int ph_snd  [N_PHASE] = '{9, 9, 56, 56, 0, 0};
    int ph_rcv  [N_PHASE] = '{56, 56, 9, 9, 0, 0};

    function automatic int eff_limit(input logic [CFG_W-1:0] v, input int depth);
        if (v == 0)
            return 1;
        return (v > depth) ? depth : int'(v);
    endfunction

    function automatic int find_in_queue(input logic [15:0] id);
        int k;
        k = -1;
        for (int i = q_cnt - 1; i >= 0; i--)
            if (q_id[i] == id)
                k = i;
        return k;
    endfunction

    function automatic int find_in_set(input logic [15:0] id);
        int k;
        k = -1;
        for (int i = SDEPTH - 1; i >= 0; i--)
            if (s_vld[i] && s_id[i] == id)
                k = i;
        return k;
    endfunction

    function automatic int set_members();
        int n;
        n = 0;
        for (int i = 0; i < SDEPTH; i++)
            if (s_vld[i])
                n++;
        return n;
    endfunction

    // Applies one command to the predicted state and returns the result it gives.
    function automatic result_t apply_cmd(input logic [CMD_W-1:0] c, input logic [15:0] id,
                                          input logic [31:0] st, input logic [POS_W-1:0] p);
        result_t r;
        int qlim;
        int slim;
        int at;
        int k;
        int scnt;
        r = '0;
        qlim = eff_limit(qlim_reg, QDEPTH);
        slim = eff_limit(slim_reg, SDEPTH);
        case (c)
            CMD_ENQUEUE:
            begin
                if (q_cnt < qlim)
                begin
                    // A new entry goes after every entry that sorts equal to it.
                    at = q_cnt;
                    for (int i = 0; i < q_cnt; i++)
                        if (at == q_cnt && (st < q_st[i] || (st == q_st[i] && id < q_id[i])))
                            at = i;
                    for (int i = q_cnt; i > at; i--)
                    begin
                        q_id[i] = q_id[i-1];
                        q_st[i] = q_st[i-1];
                    end
                    q_id[at] = id;
                    q_st[at] = st;
                    q_cnt++;
                    r.ok = 1'b1;
                end
            end
            CMD_DEQUEUE:
            begin
                k = find_in_queue(id);
                if (k >= 0)
                begin
                    for (int i = k; i + 1 < q_cnt; i++)
                    begin
                        q_id[i] = q_id[i+1];
                        q_st[i] = q_st[i+1];
                    end
                    q_cnt--;
                    r.ok = 1'b1;
                end
            end
            CMD_READ_POS:
            begin
                if (p < q_cnt)
                begin
                    r.ok = 1'b1;
                    r.entry_id = q_id[p];
                    r.entry_stamp = q_st[p];
                end
            end
            CMD_ENTER:
            begin
                if (find_in_set(id) >= 0)
                    r.ok = 1'b1;
                else if (set_members() < slim)
                begin
                    k = -1;
                    for (int i = SDEPTH - 1; i >= 0; i--)
                        if (!s_vld[i])
                            k = i;
                    s_vld[k] = 1'b1;
                    s_id[k] = id;
                    r.ok = 1'b1;
                end
            end
            CMD_LEAVE:
            begin
                k = find_in_set(id);
                if (k >= 0)
                begin
                    s_vld[k] = 1'b0;
                    r.ok = 1'b1;
                end
            end
            CMD_QUERY:
                r.ok = 1'b1;
            default:
                ;
        endcase
        scnt = set_members();
        r.in_queue = (find_in_queue(id) >= 0);
        r.in_set = (find_in_set(id) >= 0);
        r.at_head = (q_cnt > 0 && q_id[0] == id);
        r.queue_full = (q_cnt >= qlim);
        r.set_full = (scnt >= slim);
        r.queue_fill = FILL_W'(q_cnt);
        r.set_fill = FILL_W'(scnt);
        return r;
    endfunction

    function automatic result_t mk_res(input logic ok, input logic [15:0] eid,
                                       input logic [31:0] est, input logic inq,
                                       input logic ins, input logic hd, input logic qf,
                                       input logic sf, input int qfill, input int sfill);
        result_t r;
        r.ok = ok;
        r.entry_id = eid;
        r.entry_stamp = est;
        r.in_queue = inq;
        r.in_set = ins;
        r.at_head = hd;
        r.queue_full = qf;
        r.set_full = sf;
        r.queue_fill = FILL_W'(qfill);
        r.set_fill = FILL_W'(sfill);
        return r;
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [15:0] id,
                           input logic [31:0] st, input logic [POS_W-1:0] p);
        plan_row_t row;
        row = '{default: '0};
        row.c = c;
        row.id = id;
        row.st = st;
        row.p = p;
        plan = {plan, row};
    endtask

    task automatic add_lit(input logic [CMD_W-1:0] c, input logic [15:0] id,
                           input logic [31:0] st, input logic [POS_W-1:0] p,
                           input result_t want);
        add_cmd(c, id, st, p);
        plan[$].lit = 1'b1;
        plan[$].want = want;
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] ql, input logic [CFG_W-1:0] sl);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.ql = ql;
        row.sl = sl;
        plan = {plan, row};
    endtask

    // Returns at the clock edge of the transfer, with valid still high.
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [15:0] id,
                             input logic [31:0] st, input logic [POS_W-1:0] p,
                             input bit lit, input result_t want);
        result_t r;
        while ($urandom_range(0, 99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= c;
        req_ch.req_id <= id;
        req_ch.stamp <= st;
        req_ch.pos <= p;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = apply_cmd(c, id, st, p);
        awaited_res = {awaited_res, (lit ? want : r)};
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (awaited_res.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] ql, input logic [CFG_W-1:0] sl);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_QUEUE_LIMIT;
        cfg_data <= ql;
        @(posedge clk);
        cfg_idx <= CFG_INSIDE_LIMIT;
        cfg_data <= sl;
        @(posedge clk);
        cfg_we <= 1'b0;
        qlim_reg = ql;
        slim_reg = sl;
    endtask

    // Mostly a small pool of ids and stamps, so that ties, duplicates and hits are common.
    task automatic rand_item();
        logic [CMD_W-1:0] c;
        logic [15:0]      id;
        logic [31:0]      st;
        int               r;
        int               k;
        r = $urandom_range(0, 99);
        if (r < 30)
            c = CMD_ENQUEUE;
        else if (r < 50)
            c = CMD_DEQUEUE;
        else if (r < 62)
            c = CMD_READ_POS;
        else if (r < 75)
            c = CMD_ENTER;
        else if (r < 87)
            c = CMD_LEAVE;
        else if (r < 95)
            c = CMD_QUERY;
        else
            c = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        if ($urandom_range(0, 4) == 0)
            id = 16'($urandom);
        else
            id = 16'($urandom_range(0, 7));
        if (c == CMD_DEQUEUE && q_cnt > 0 && $urandom_range(0, 3) != 0)
            id = q_id[$urandom_range(0, q_cnt - 1)];
        if (c == CMD_LEAVE && $urandom_range(0, 3) != 0)
        begin
            k = $urandom_range(0, SDEPTH - 1);
            if (s_vld[k])
                id = s_id[k];
        end
        case ($urandom_range(0, 9))
            0: st = 32'h0;
            1: st = 32'hFFFF_FFFF;
            2, 3: st = $urandom;
            default: st = $urandom_range(0, 15);
        endcase
        send_item(c, id, st, POS_W'($urandom_range(0, 15)), 1'b0, '0);
    endtask

    task automatic chk(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: takes transfers and compares them with the oldest prediction.
    initial
    begin
        result_t want;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_res.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, expected none, got ok=%0b",
                             $time, rsp_ch.ok);
                    errors++;
                end
                else
                begin
                    want = awaited_res.pop_front();
                    chk("ok", want.ok, rsp_ch.ok);
                    chk("entry_id", want.entry_id, rsp_ch.entry_id);
                    chk("entry_stamp", want.entry_stamp, rsp_ch.entry_stamp);
                    chk("in_queue", want.in_queue, rsp_ch.in_queue);
                    chk("in_set", want.in_set, rsp_ch.in_set);
                    chk("at_head", want.at_head, rsp_ch.at_head);
                    chk("queue_full", want.queue_full, rsp_ch.queue_full);
                    chk("set_full", want.set_full, rsp_ch.set_full);
                    chk("queue_fill", want.queue_fill, rsp_ch.queue_fill);
                    chk("set_fill", want.set_fill, rsp_ch.set_fill);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timestamp_ordered_request_queue test failed");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        q_cnt = 0;
        for (int i = 0; i < SDEPTH; i++)
            s_vld[i] = 1'b0;
        qlim_reg = LIMIT_RESET;
        slim_reg = LIMIT_RESET;
        snd_idle = ph_snd[0];
        rcv_idle = ph_rcv[0];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_QUEUE_LIMIT;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_QUERY;
        req_ch.req_id = '0;
        req_ch.stamp = '0;
        req_ch.pos = '0;

        // Directed part: empty-block corner cases, sort extremes and ties, then rejections.
        add_lit(CMD_QUERY, 16'h0005, 32'h0, 4'd0, mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_READ_POS, 16'h8000, 32'h0, 4'd0, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_DEQUEUE, 16'h0005, 32'h0, 4'd0, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_LEAVE, 16'h0005, 32'h0, 4'd0, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_SPARE6, 16'h0000, 32'h0, 4'd0, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_SPARE7, 16'hFFFF, 32'hFFFF_FFFF, 4'd15,
                mk_res(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_lit(CMD_ENQUEUE, 16'hFFFF, 32'hFFFF_FFFF, 4'd0,
                mk_res(1, 0, 0, 1, 0, 1, 0, 0, 1, 0));
        add_lit(CMD_ENQUEUE, 16'h0000, 32'h0, 4'd0, mk_res(1, 0, 0, 1, 0, 1, 0, 0, 2, 0));
        add_cmd(CMD_ENQUEUE, 16'h0007, 32'd100, 4'd0);
        add_cmd(CMD_ENQUEUE, 16'h0003, 32'd100, 4'd0);
        add_cmd(CMD_ENQUEUE, 16'h0007, 32'd100, 4'd0);
        add_cmd(CMD_READ_POS, 16'h0003, 32'h0, 4'd1);
        add_lit(CMD_READ_POS, 16'h1234, 32'h0, 4'd15, mk_res(0, 0, 0, 0, 0, 0, 0, 0, 5, 0));
        add_cmd(CMD_DEQUEUE, 16'h0007, 32'h0, 4'd0);
        add_cmd(CMD_ENTER, 16'hAAAA, 32'h0, 4'd0);
        add_cmd(CMD_ENTER, 16'hAAAA, 32'h0, 4'd0);
        add_cmd(CMD_ENTER, 16'h5555, 32'h0, 4'd0);
        // Set limit down to its fill, queue limit below fill: both report full.
        add_cfg(5'd16, 5'd2);
        add_cmd(CMD_ENTER, 16'h0001, 32'h0, 4'd0);
        add_cfg(5'd0, 5'd2);
        add_cmd(CMD_ENQUEUE, 16'h0001, 32'd5, 4'd0);
        add_cmd(CMD_DEQUEUE, 16'h0000, 32'h0, 4'd0);
        add_cmd(CMD_LEAVE, 16'h5555, 32'h0, 4'd0);
        add_cfg(5'd31, 5'd0);
        add_cmd(CMD_READ_POS, 16'h0003, 32'h0, 4'd0);
        add_cmd(CMD_QUERY, 16'h0003, 32'h0, 4'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                set_limits(plan[i].ql, plan[i].sl);
            end
            else
                send_item(plan[i].c, plan[i].id, plan[i].st, plan[i].p,
                          plan[i].lit, plan[i].want);
        end

        for (int ph = 0; ph < N_PHASE; ph++)
        begin
            wait_idle();
            set_limits(CFG_W'(ph_qlim[ph]), CFG_W'(ph_slim[ph]));
            snd_idle = ph_snd[ph];
            rcv_idle = ph_rcv[ph];
            repeat (PHASE_ITEMS) rand_item();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && awaited_res.size() == 0)
            $display("timestamp_ordered_request_queue test passed");
        else
            $display("timestamp_ordered_request_queue test failed");
        $finish;
    end

endmodule
